// File: hdl/fifo_with_second_max_query_defines.svh
// Assertion macros shared by the FIFO second-highest query block.
// Used by fsmq_rank and fifo_with_second_max_query; expects clk_i and rst_ni in scope.
`ifndef FIFO_WITH_SECOND_MAX_QUERY_DEFINES_SVH
`define FIFO_WITH_SECOND_MAX_QUERY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define FSMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FSMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fsmq_pkg.sv
// Package for the FIFO with second-highest query: sizes, kind codes, item types.
// No dependencies; imported by fsmq_rank and fifo_with_second_max_query.
`timescale 1ns / 1ps
`default_nettype none

package fsmq_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Item kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] front_value;
    logic [CNT_W-1:0]             entry_count;
    logic                         push_dropped;
    logic signed [VALUE_BITS-1:0] second_value;
    logic                         second_found;
  } out_item_t;

  // Step a ring index, wrapping at DEPTH
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fsmq_rank.sv
// Compare unit: keeps the highest and second-highest distinct value seen.
// Depends on fsmq_pkg and the assertion macros in fifo_with_second_max_query_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_with_second_max_query_defines.svh"

module fsmq_rank
  import fsmq_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire logic                         en_i,
  input  wire logic signed [VALUE_BITS-1:0] data_i,
  output logic                              found_o,
  output logic signed [VALUE_BITS-1:0]      second_o
);

  logic                         have_first_q, have_first_d;
  logic                         have_second_q, have_second_d;
  logic signed [VALUE_BITS-1:0] first_q, first_d;
  logic signed [VALUE_BITS-1:0] second_q, second_d;

  // One entry per cycle against the running pair, taken only while en_i is high
  always_comb begin
    have_first_d  = have_first_q;
    have_second_d = have_second_q;
    first_d       = first_q;
    second_d      = second_q;
    if (clear_i) begin
      have_first_d  = 1'b0;
      have_second_d = 1'b0;
    end else if (en_i) begin
      if (!have_first_q || (data_i > first_q)) begin
        if (have_first_q) begin
          have_second_d = 1'b1;
          second_d      = first_q;
        end
        have_first_d = 1'b1;
        first_d      = data_i;
      end else if ((data_i != first_q) && (!have_second_q || (data_i > second_q))) begin
        have_second_d = 1'b1;
        second_d      = data_i;
      end
    end
  end

  // Flags reset; values only matter once flagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q  <= 1'b0;
      have_second_q <= 1'b0;
    end else begin
      have_first_q  <= have_first_d;
      have_second_q <= have_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  assign found_o  = have_second_q;
  assign second_o = have_second_q ? second_q : '0;

  `FSMQ_ASSERT_NOW(a_second_needs_first, have_second_q, have_first_q, "second without first")
  `FSMQ_ASSERT_NOW(a_second_below_first, have_second_q, second_q < first_q, "second not below first")
  `FSMQ_ASSERT_NEXT(a_clear_drops_found, clear_i, !have_second_q, "clear left found set")

endmodule

`default_nettype wire

// File: hdl/fifo_with_second_max_query.sv
// Sequence: push, pop, unused kind and a query on fewer than two entries step
// through S_FRONT and S_OUT, and done_o is high in S_OUT. A query with n >= 2 entries
// held steps through S_SCAN, S_DRAIN, S_FRONT and S_OUT; S_SCAN reads one ring entry
// per cycle into the compare unit. Busy stays high through the done_o cycle, so the
// next item is not taken before the sequencer is back in S_IDLE.
// Reset (rst_ni low, asynchronous) empties the queue; ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_with_second_max_query_defines.svh"

module fifo_with_second_max_query
  import fsmq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire in_item_t  item_i,
  output logic           busy,
  output logic           done_o,
  output out_item_t      result_o
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] oldest_q, oldest_d;
  logic [IDX_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0] scan_n_q, scan_n_d;
  logic             rd_vld_q, rd_vld_d;
  logic             dropped_q, dropped_d;

  logic                         accept;
  logic                         mem_we;
  logic [IDX_W-1:0]             raddr;
  logic signed [VALUE_BITS-1:0] rdata_q;
  logic signed [VALUE_BITS-1:0] mem [DEPTH];

  logic                         rank_found;
  logic signed [VALUE_BITS-1:0] rank_second;

  assign accept = start && !busy;

  // Sequencer and ring pointers
  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    wr_d       = wr_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    scan_n_d   = scan_n_q;
    dropped_d  = dropped_q;
    rd_vld_d   = 1'b0;
    mem_we     = 1'b0;
    raddr      = oldest_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dropped_d = 1'b0;
          state_d   = S_FRONT;
          case (item_i.kind)
            KIND_PUSH: begin
              if (count_q == CNT_W'(DEPTH)) begin
                dropped_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                wr_d    = ring_next(wr_q);
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_POP: begin
              if (count_q != '0) begin
                oldest_d = ring_next(oldest_q);
                count_d  = count_q - CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              if (count_q >= CNT_W'(2)) begin
                state_d    = S_SCAN;
                scan_idx_d = oldest_q;
                scan_n_d   = '0;
              end
            end
            default: begin
              state_d = S_FRONT;
            end
          endcase
        end
      end
      S_SCAN: begin
        raddr      = scan_idx_q;
        rd_vld_d   = 1'b1;
        scan_idx_d = ring_next(scan_idx_q);
        scan_n_d   = scan_n_q + CNT_W'(1);
        if (scan_n_q == count_q - CNT_W'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FRONT;
      end
      S_FRONT: begin
        raddr   = oldest_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      oldest_q   <= '0;
      wr_q       <= '0;
      count_q    <= '0;
      scan_idx_q <= '0;
      scan_n_q   <= '0;
      rd_vld_q   <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      oldest_q   <= oldest_d;
      wr_q       <= wr_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      scan_n_q   <= scan_n_d;
      rd_vld_q   <= rd_vld_d;
      dropped_q  <= dropped_d;
    end
  end

  // Ring memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_q] <= item_i.value;
    end
    rdata_q <= mem[raddr];
  end

  // Compare unit fed by the scan reads
  fsmq_rank u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (accept),
    .en_i     (rd_vld_q),
    .data_i   (rdata_q),
    .found_o  (rank_found),
    .second_o (rank_second)
  );

  // Result assembly
  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

  always_comb begin
    result_o.front_value  = (count_q == '0) ? {VALUE_BITS{1'b1}} : rdata_q;
    result_o.entry_count  = count_q;
    result_o.push_dropped = dropped_q;
    result_o.second_value = rank_second;
    result_o.second_found = rank_found;
  end

  `FSMQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `FSMQ_ASSERT_NOW(a_scan_needs_two, state_q == S_SCAN, count_q >= CNT_W'(2), "scan with under two entries")
  `FSMQ_ASSERT_NEXT(a_done_frees, done_o, !busy && !done_o, "busy held after result")
  `FSMQ_ASSERT_NEXT(a_pop_empty, accept && item_i.kind == KIND_POP && count_q == '0, count_q == '0, "pop on empty changed count")

endmodule

`default_nettype wire
